[rtl/pim_pkg.sv]
// pim_pkg: shared widths, constants, config register codes and the
// measurement word passed from the capture front end to the divider back end.
// No dependencies.
package pim_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CAP_W          = 16;
  localparam int CNT_W          = 16;
  localparam int PERIOD_W       = 32;
  localparam int FREQ_W         = 27;
  localparam int DUTY_W         = 16;
  localparam int PROD_W         = PERIOD_W + DUTY_W;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 27;

  localparam logic [CNT_W-1:0]  CNT_MAX         = 16'hFFFF;
  localparam logic [FREQ_W-1:0] SRC_FREQ_RESET  = 27'd1000000;
  localparam logic [DUTY_W-1:0] DUTY_SCALE_RESET = 16'd10000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_FREQ   = 2'd0,
    CFG_DUTY_SCALE = 2'd1
  } cfg_idx_t;

  // one measurement word: period and high time in timer ticks
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] high_time;
  } meas_t;

endpackage

[rtl/pim_front.sv]
// pim_front: capture front end, keeps overflow count, last rise and the
// measured period and high time, and pushes one measurement word per accepted input word.
// Depends on pim_pkg.
module pim_front #(
  parameter int TIMER_BITS = pim_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_overflow_event,
  input  logic                       in_rise_event,
  input  logic [pim_pkg::CAP_W-1:0]  in_rise_capture,
  input  logic                       in_fall_event,
  input  logic [pim_pkg::CAP_W-1:0]  in_fall_capture,
  input  logic                       q_full,
  output logic                       q_push,
  output pim_pkg::meas_t             q_wdata
);
  import pim_pkg::*;

  localparam int EW = (TIMER_BITS + CNT_W + 1 > PERIOD_W + 1) ?
                      TIMER_BITS + CNT_W + 1 : PERIOD_W + 1;

  logic [CNT_W-1:0]      ovf_cnt_r;
  logic [TIMER_BITS-1:0] last_rise_r;
  logic                  rise_seen_r;
  logic [PERIOD_W-1:0]   period_r;
  logic [PERIOD_W-1:0]   high_r;

  logic [TIMER_BITS-1:0] rcap, fcap;
  logic [CNT_W-1:0]      cnt_ovf, ovf_cnt_nxt;
  logic [TIMER_BITS-1:0] last_rise_nxt;
  logic                  rise_seen_nxt;
  logic [PERIOD_W-1:0]   period_nxt, high_nxt;
  logic                  accept;

  // elapsed ticks from last rise to a capture, saturated to 32 bits
  function automatic logic [PERIOD_W-1:0] elapsed(
    input logic [TIMER_BITS-1:0] cap,
    input logic [TIMER_BITS-1:0] last,
    input logic [CNT_W-1:0]      n
  );
    logic [CNT_W-1:0] n_eff;
    logic [EW-1:0]    base;
    logic [EW-1:0]    t;
    // a wrap with no counted overflow still spans one timer period
    n_eff = (cap < last && n == '0) ? CNT_W'(1) : n;
    base  = EW'({n_eff, {TIMER_BITS{1'b0}}});
    if (cap >= last) t = base + EW'(cap - last);
    else             t = base - EW'(last - cap);
    if (|t[EW-1:PERIOD_W]) return '1;
    return t[PERIOD_W-1:0];
  endfunction

  assign rcap     = TIMER_BITS'(in_rise_capture);
  assign fcap     = TIMER_BITS'(in_fall_capture);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // overflow, then rise, then fall
  always_comb begin
    cnt_ovf = ovf_cnt_r;
    if (in_overflow_event && ovf_cnt_r != CNT_MAX) cnt_ovf = ovf_cnt_r + CNT_W'(1);
    ovf_cnt_nxt   = cnt_ovf;
    last_rise_nxt = last_rise_r;
    rise_seen_nxt = rise_seen_r;
    period_nxt    = period_r;
    high_nxt      = high_r;
    if (in_rise_event) begin
      period_nxt    = rise_seen_r ? elapsed(rcap, last_rise_r, cnt_ovf) : '0;
      ovf_cnt_nxt   = '0;
      last_rise_nxt = rcap;
      rise_seen_nxt = 1'b1;
    end
    if (in_fall_event && rise_seen_nxt) begin
      high_nxt = elapsed(fcap, last_rise_nxt, ovf_cnt_nxt);
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_cnt_r   <= '0;
      last_rise_r <= '0;
      rise_seen_r <= 1'b0;
      period_r    <= '0;
      high_r      <= '0;
    end else if (accept) begin
      ovf_cnt_r   <= ovf_cnt_nxt;
      last_rise_r <= last_rise_nxt;
      rise_seen_r <= rise_seen_nxt;
      period_r    <= period_nxt;
      high_r      <= high_nxt;
    end
  end

  // hand the word to the queue
  assign q_push            = accept;
  assign q_wdata.period    = period_nxt;
  assign q_wdata.high_time = high_nxt;

endmodule

[rtl/pim_queue.sv]
// pim_queue: two-entry queue of measurement words between front and back end.
// Depends on pim_pkg.
module pim_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pim_pkg::meas_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           rvalid,
  output pim_pkg::meas_t rdata
);
  import pim_pkg::*;

  meas_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full   = cnt_r == 2'd2;
  assign rvalid = cnt_r != 2'd0;
  assign rdata  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/pim_back.sv]
// pim_back: divider back end, computes frequency and duty from a measurement
// word with two restoring dividers stepped together, one quotient bit a cycle.
// Depends on pim_pkg.
module pim_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pim_pkg::FREQ_W-1:0]      src_freq,
  input  logic [pim_pkg::DUTY_W-1:0]      duty_scale,
  input  logic                            q_valid,
  input  pim_pkg::meas_t                  q_rdata,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pim_pkg::PERIOD_W-1:0]    out_period_out,
  output logic [pim_pkg::PERIOD_W-1:0]    out_high_time_out,
  output logic [pim_pkg::FREQ_W-1:0]      out_frequency_out,
  output logic [pim_pkg::DUTY_W-1:0]      out_duty_out
);
  import pim_pkg::*;

  localparam int STEP_W = $clog2(FREQ_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [PERIOD_W-1:0] per_r, hi_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PERIOD_W-1:0] rem_f_r, rem_d_r;
  logic [FREQ_W-1:0]   num_f_r;
  logic [DUTY_W-1:0]   num_d_r;
  logic                out_valid_r;
  logic [PERIOD_W-1:0] o_per_r, o_hi_r;
  logic [FREQ_W-1:0]   o_freq_r;
  logic [DUTY_W-1:0]   o_duty_r;

  logic [PERIOD_W:0]   sh_f, sh_d, sub_f, sub_d;
  logic                ge_f, ge_d, last_step, out_free;

  // one restoring step for each divider
  always_comb begin
    sh_f  = {rem_f_r, num_f_r[FREQ_W-1]};
    sh_d  = {rem_d_r, num_d_r[DUTY_W-1]};
    ge_f  = sh_f >= {1'b0, per_r};
    ge_d  = sh_d >= {1'b0, per_r};
    sub_f = sh_f - {1'b0, per_r};
    sub_d = sh_d - {1'b0, per_r};
  end

  assign last_step = step_r == STEP_W'(FREQ_W - 1);
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (last_step) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath: multiply on pop, then divide
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        per_r  <= q_rdata.period;
        hi_r   <= q_rdata.high_time;
        prod_r <= PROD_W'(q_rdata.high_time) * PROD_W'(duty_scale);
      end
      S_LOAD: begin
        step_r  <= '0;
        rem_f_r <= '0;
        num_f_r <= src_freq;
        // high <= period keeps the upper product part below the period
        rem_d_r <= prod_r[PROD_W-1:DUTY_W];
        num_d_r <= prod_r[DUTY_W-1:0];
      end
      S_DIV: begin
        step_r  <= step_r + STEP_W'(1);
        rem_f_r <= ge_f ? sub_f[PERIOD_W-1:0] : sh_f[PERIOD_W-1:0];
        num_f_r <= {num_f_r[FREQ_W-2:0], ge_f};
        if (step_r < STEP_W'(DUTY_W)) begin
          rem_d_r <= ge_d ? sub_d[PERIOD_W-1:0] : sh_d[PERIOD_W-1:0];
          num_d_r <= {num_d_r[DUTY_W-2:0], ge_d};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      o_per_r  <= per_r;
      o_hi_r   <= hi_r;
      o_freq_r <= (per_r == '0) ? '0 : num_f_r;
      o_duty_r <= (per_r == '0 || hi_r > per_r) ? '0 : num_d_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_period_out    = o_per_r;
  assign out_high_time_out = o_hi_r;
  assign out_frequency_out = o_freq_r;
  assign out_duty_out      = o_duty_r;

endmodule

[rtl/pwm_input_period_duty_meter.sv]
// The back end takes one word at a time: it pops a word, loads its dividers,
// runs the 27-step serial divider and registers the result word before it pops
// the next; the front end keeps accepting into a two-word queue until it is full.
// Synchronous active-low reset clears the measurement state, the queue and
// the sequencer, and restores source_frequency 1000000 and duty_scale 10000.
// Depends on pim_pkg, pim_front, pim_queue and pim_back.
module pwm_input_period_duty_meter #(
  parameter int TIMER_BITS = pim_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_overflow_event,
  input  logic                              in_rise_event,
  input  logic [pim_pkg::CAP_W-1:0]         in_rise_capture,
  input  logic                              in_fall_event,
  input  logic [pim_pkg::CAP_W-1:0]         in_fall_capture,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pim_pkg::PERIOD_W-1:0]      out_period_out,
  output logic [pim_pkg::PERIOD_W-1:0]      out_high_time_out,
  output logic [pim_pkg::FREQ_W-1:0]        out_frequency_out,
  output logic [pim_pkg::DUTY_W-1:0]        out_duty_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pim_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pim_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pim_pkg::*;

  logic [FREQ_W-1:0] src_freq_r;
  logic [DUTY_W-1:0] duty_scale_r;
  logic              q_push, q_full, q_pop, q_valid;
  meas_t             q_wdata, q_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_freq_r   <= SRC_FREQ_RESET;
      duty_scale_r <= DUTY_SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SRC_FREQ:   src_freq_r   <= cfg_data[FREQ_W-1:0];
        CFG_DUTY_SCALE: duty_scale_r <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // capture front end
  pim_front #(.TIMER_BITS(TIMER_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_overflow_event (in_overflow_event),
    .in_rise_event     (in_rise_event),
    .in_rise_capture   (in_rise_capture),
    .in_fall_event     (in_fall_event),
    .in_fall_capture   (in_fall_capture),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  // decoupling queue
  pim_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // divider back end
  pim_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .src_freq          (src_freq_r),
    .duty_scale        (duty_scale_r),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_period_out    (out_period_out),
    .out_high_time_out (out_high_time_out),
    .out_frequency_out (out_frequency_out),
    .out_duty_out      (out_duty_out)
  );

endmodule

[rtl/pim_checker.sv]
// pim_checker: port-level assertions for the meter, bound to the top level.
// Depends on pim_pkg.
module pim_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pim_pkg::PERIOD_W-1:0]   out_period_out,
  input logic [pim_pkg::PERIOD_W-1:0]   out_high_time_out,
  input logic [pim_pkg::FREQ_W-1:0]     out_frequency_out,
  input logic [pim_pkg::DUTY_W-1:0]     out_duty_out
);
  import pim_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period_out) &&
    $stable(out_high_time_out) && $stable(out_frequency_out) && $stable(out_duty_out))
    else $error("result word changed while stalled");

  // unknown period gives zero frequency and duty
  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period_out == '0 |-> out_frequency_out == '0 && out_duty_out == '0)
    else $error("nonzero frequency or duty with zero period");

  // high time beyond period gives zero duty
  a_high_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_high_time_out > out_period_out |-> out_duty_out == '0)
    else $error("nonzero duty with high time above period");

  // no result word right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind pwm_input_period_duty_meter pim_checker u_pim_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_period_out    (out_period_out),
  .out_high_time_out (out_high_time_out),
  .out_frequency_out (out_frequency_out),
  .out_duty_out      (out_duty_out)
);
